/* rtl/core/jbq_pkg.sv */
// Shared types, codes, widths and quantization tables of the JPEG block quantizer.
package jbq_pkg;

	// Field widths
	localparam int CoeffWidth = 16;
	localparam int EntryWidth = 8;
	localparam int PosWidth = 6;
	localparam int TableDepth = 64;

	// Configuration port
	localparam int CfgIndexWidth = 1;
	localparam int CfgDataWidth = 2;
	localparam logic [CfgIndexWidth-1:0] RegTableSel = 1'b0;
	localparam logic [CfgIndexWidth-1:0] RegDirection = 1'b1;

	// Table select codes; the unused code falls back to the user table
	localparam logic [1:0] TblLum = 2'd0;
	localparam logic [1:0] TblChr = 2'd1;
	localparam logic [1:0] TblUser = 2'd2;

	// Direction codes
	localparam logic DirFwd = 1'b0;
	localparam logic DirInv = 1'b1;

	// Input item modes
	localparam logic ModeLoad = 1'b0;
	localparam logic ModeCoeff = 1'b1;

	// Queue depth defaults
	localparam int MqDepthDefault = 4;
	localparam int OqDepthDefault = 32;

	typedef struct packed {
		logic                         mode;
		logic [PosWidth-1:0]          position;
		logic signed [CoeffWidth-1:0] value;
	} jbq_in_t;

	typedef struct packed {
		logic signed [CoeffWidth-1:0] result;
		logic                         saturated;
	} jbq_out_t;

	// Classified coefficient handed from the front to the back
	typedef struct packed {
		logic signed [CoeffWidth-1:0] value;
		logic [EntryWidth-1:0]        entry;
	} jbq_work_t;

	localparam logic [EntryWidth-1:0] LumTab [TableDepth] = '{
		8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
		8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
		8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
		8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
		8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
		8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
		8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
		8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99
	};

	localparam logic [EntryWidth-1:0] ChrTab [TableDepth] = '{
		8'd17, 8'd18, 8'd24, 8'd47, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd18, 8'd21, 8'd26, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd24, 8'd26, 8'd56, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd47, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99
	};

endpackage

/* rtl/core/jbq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module jbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/jbq_fifo.sv */
// Small register-based FIFO used between the front and back and at the result side.
module jbq_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNTW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic [CNTW-1:0]  count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [CNTW-1:0]  count_q;

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNTW'(1);
			end else if (!push && pop) begin
				count_q <= count_q - CNTW'(1);
			end
		end
	end

	assign rdata = mem_q[rptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

endmodule

/* rtl/core/jbq_front.sv */
// Front end: accepts items, loads the user table and looks up each coefficient's entry.
module jbq_front #(
	parameter int MQ_DEPTH = jbq_pkg::MqDepthDefault,
	localparam int CNTW = $clog2(MQ_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  jbq_pkg::jbq_in_t  in_item,
	input  logic [1:0]        table_select,
	input  logic [CNTW-1:0]   mq_count,
	output logic              wk_push,
	output jbq_pkg::jbq_work_t wk_data
);

	localparam int EW = jbq_pkg::EntryWidth;
	localparam int PW = jbq_pkg::PosWidth;
	localparam int CW = jbq_pkg::CoeffWidth;

	logic                 accept;
	logic                 load_wr;
	logic                 coeff_rd;
	logic [EW-1:0]        load_entry;
	logic [EW-1:0]        user_entry;
	logic                 v_s1;
	logic [PW-1:0]        pos_s1;
	logic signed [CW-1:0] val_s1;
	logic [EW-1:0]        entry_s1;
	logic [CNTW:0]        level;

	// Hold off input while the queue plus the lookup stage could overflow
	assign level  = {1'b0, mq_count} + (CNTW + 1)'(v_s1);
	assign full   = (level >= (CNTW + 1)'(MQ_DEPTH));
	assign accept = push && !full;

	// Classify the item
	assign load_wr  = accept && (in_item.mode == jbq_pkg::ModeLoad);
	assign coeff_rd = accept && (in_item.mode == jbq_pkg::ModeCoeff);

	// A loaded zero is stored as one
	assign load_entry = (in_item.value[EW-1:0] == '0) ? EW'(1) : in_item.value[EW-1:0];

	jbq_ram #(
		.WIDTH (EW),
		.DEPTH (jbq_pkg::TableDepth)
	) u_user_tab (
		.clk   (clk),
		.we    (load_wr),
		.waddr (in_item.position),
		.wdata (load_entry),
		.re    (coeff_rd),
		.raddr (in_item.position),
		.rdata (user_entry)
	);

	// Lookup stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= coeff_rd;
		end
	end

	// Lookup stage payload
	always_ff @(posedge clk) begin
		if (coeff_rd) begin
			pos_s1 <= in_item.position;
			val_s1 <= in_item.value;
		end
	end

	// Select the table entry
	always_comb begin
		case (table_select)
			jbq_pkg::TblLum: entry_s1 = jbq_pkg::LumTab[pos_s1];
			jbq_pkg::TblChr: entry_s1 = jbq_pkg::ChrTab[pos_s1];
			default:         entry_s1 = user_entry;
		endcase
	end

	assign wk_push       = v_s1;
	assign wk_data.value = val_s1;
	assign wk_data.entry = entry_s1;

endmodule

/* rtl/core/jbq_back.sv */
// Back end: pipelined restoring divider and saturating multiplier with result credits.
module jbq_back #(
	parameter int OQ_DEPTH = jbq_pkg::OqDepthDefault,
	localparam int RW = $clog2(OQ_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wk_valid,
	input  jbq_pkg::jbq_work_t wk_data,
	output logic               wk_pop,
	input  logic               direction,
	input  logic               res_pop,
	output logic               res_push,
	output jbq_pkg::jbq_out_t  res_data
);

	localparam int CW = jbq_pkg::CoeffWidth;
	localparam int EW = jbq_pkg::EntryWidth;
	localparam int NS = CW;
	localparam int PW = CW + EW + 1;
	localparam logic signed [PW-1:0] ProdHi = PW'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [PW-1:0] ProdLo = ~ProdHi;

	logic [RW-1:0]        rsv_q;
	logic                 issue;
	logic [CW-1:0]        mag;
	logic signed [PW-1:0] op_a;
	logic signed [PW-1:0] op_b;
	logic                 rnd;

	logic [NS:0]          vld_sn;
	logic                 neg_sn  [NS+1];
	logic                 dir_sn  [NS+1];
	logic [EW-1:0]        ent_sn  [NS+1];
	logic [CW-1:0]        dvd_sn  [NS+1];
	logic [CW-1:0]        quo_sn  [NS+1];
	logic [EW-1:0]        rem_sn  [NS+1];
	logic signed [PW-1:0] prod_sn [NS+1];

	// Issue only when the result queue has a reserved slot
	assign issue  = wk_valid && (rsv_q < RW'(OQ_DEPTH));
	assign wk_pop = issue;

	// Count results in flight or waiting in the result queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_q <= '0;
		end else if (issue && !res_pop) begin
			rsv_q <= rsv_q + RW'(1);
		end else if (!issue && res_pop) begin
			rsv_q <= rsv_q - RW'(1);
		end
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else begin
			vld_sn <= {vld_sn[NS-1:0], issue};
		end
	end

	// Entry stage: magnitude for the divider and the full product
	assign mag  = wk_data.value[CW-1] ? (~wk_data.value + CW'(1)) : wk_data.value;
	assign op_a = {{(PW - CW){wk_data.value[CW-1]}}, wk_data.value};
	assign op_b = {{(PW - EW){1'b0}}, wk_data.entry};

	always_ff @(posedge clk) begin
		neg_sn[0]  <= wk_data.value[CW-1];
		dir_sn[0]  <= direction;
		ent_sn[0]  <= wk_data.entry;
		dvd_sn[0]  <= mag;
		quo_sn[0]  <= '0;
		rem_sn[0]  <= '0;
		prod_sn[0] <= op_a * op_b;
	end

	// One quotient bit per stage
	for (genvar k = 1; k <= NS; k++) begin : g_stage
		logic [EW:0] trial;
		logic [EW:0] diff;
		logic        ge;

		always_comb begin
			trial = {rem_sn[k-1], dvd_sn[k-1][CW-1]};
			diff  = trial - {1'b0, ent_sn[k-1]};
			ge    = (trial >= {1'b0, ent_sn[k-1]});
		end

		always_ff @(posedge clk) begin
			rem_sn[k]  <= ge ? diff[EW-1:0] : trial[EW-1:0];
			quo_sn[k]  <= {quo_sn[k-1][CW-2:0], ge};
			dvd_sn[k]  <= {dvd_sn[k-1][CW-2:0], 1'b0};
			neg_sn[k]  <= neg_sn[k-1];
			dir_sn[k]  <= dir_sn[k-1];
			ent_sn[k]  <= ent_sn[k-1];
			prod_sn[k] <= prod_sn[k-1];
		end
	end

	// Round half up for positive values, clamp products
	assign rnd = !neg_sn[NS] && ({rem_sn[NS], 1'b0} >= {1'b0, ent_sn[NS]});

	always_comb begin
		res_data.saturated = 1'b0;
		if (dir_sn[NS] == jbq_pkg::DirInv) begin
			if (prod_sn[NS] > ProdHi) begin
				res_data.result    = ProdHi[CW-1:0];
				res_data.saturated = 1'b1;
			end else if (prod_sn[NS] < ProdLo) begin
				res_data.result    = ProdLo[CW-1:0];
				res_data.saturated = 1'b1;
			end else begin
				res_data.result = prod_sn[NS][CW-1:0];
			end
		end else if (neg_sn[NS]) begin
			res_data.result = ~quo_sn[NS] + CW'(1);
		end else begin
			res_data.result = quo_sn[NS] + CW'(rnd);
		end
	end

	assign res_push = vld_sn[NS];

endmodule

/* rtl/core/jpeg_block_quantizer_core.sv */
// Top level of the JPEG block quantizer: config registers, front, queues and back.
//
// Usage:
//  Input channel: push / full / in_item. An item transfers on a clock edge with
//  push high and full low. Mode load writes the low 8 bits of value into the
//  user table slot given by position (zero is stored as one) and gives no
//  result. Mode coefficient quantizes (divide, round half up when positive,
//  truncate toward zero when negative) or dequantizes (multiply, clamp to 16
//  bits and flag) with the entry of the selected table at position.
//  Result channel: empty / pop / out_item, oldest result first; it transfers
//  on a clock edge with pop high and empty low.
//  Config: cfg_we writes cfg_wdata into register cfg_addr (0 table select,
//  1 direction) on the same edge; write only while the block is idle.
//  Pipeline: one table lookup, one queue stage, the multiply stage and
//  sixteen restoring divider stages, one quotient bit per stage, before the
//  result queue. Throughput: one item per cycle while full stays low.
//  Stall: with pop held low the result queue fills, issue into the divider
//  stops once its slots are all reserved, and full rises once the work queue
//  and the lookup stage hold MQ_DEPTH items.
//  Reset: clears registers and queues; user table contents are undefined
//  until loaded.
module jpeg_block_quantizer_core #(
	parameter int MQ_DEPTH = jbq_pkg::MqDepthDefault,
	parameter int OQ_DEPTH = jbq_pkg::OqDepthDefault
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  jbq_pkg::jbq_in_t                      in_item,
	output logic                                  empty,
	input  logic                                  pop,
	output jbq_pkg::jbq_out_t                     out_item,
	input  logic                                  cfg_we,
	input  logic [jbq_pkg::CfgIndexWidth-1:0]     cfg_addr,
	input  logic [jbq_pkg::CfgDataWidth-1:0]      cfg_wdata
);

	localparam int MQCW = $clog2(MQ_DEPTH + 1);

	logic [1:0]         table_select_q;
	logic               direction_q;
	logic               wk_push;
	jbq_pkg::jbq_work_t wk_wdata;
	jbq_pkg::jbq_work_t wk_rdata;
	logic               wk_empty;
	logic               wk_pop;
	logic [MQCW-1:0]    mq_count;
	logic               res_push;
	jbq_pkg::jbq_out_t  res_data;
	logic               res_pop;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_select_q <= jbq_pkg::TblLum;
			direction_q    <= jbq_pkg::DirFwd;
		end else if (cfg_we) begin
			case (cfg_addr)
				jbq_pkg::RegTableSel:  table_select_q <= cfg_wdata[1:0];
				jbq_pkg::RegDirection: direction_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	jbq_front #(
		.MQ_DEPTH (MQ_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.in_item      (in_item),
		.table_select (table_select_q),
		.mq_count     (mq_count),
		.wk_push      (wk_push),
		.wk_data      (wk_wdata)
	);

	jbq_fifo #(
		.WIDTH ($bits(jbq_pkg::jbq_work_t)),
		.DEPTH (MQ_DEPTH)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (wk_push),
		.wdata  (wk_wdata),
		.pop    (wk_pop),
		.rdata  (wk_rdata),
		.empty  (wk_empty),
		.count  (mq_count)
	);

	jbq_back #(
		.OQ_DEPTH (OQ_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.wk_valid  (!wk_empty),
		.wk_data   (wk_rdata),
		.wk_pop    (wk_pop),
		.direction (direction_q),
		.res_pop   (res_pop),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// Result transfer
	assign res_pop = pop && !empty;

	jbq_fifo #(
		.WIDTH ($bits(jbq_pkg::jbq_out_t)),
		.DEPTH (OQ_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.pop    (res_pop),
		.rdata  (out_item),
		.empty  (empty),
		.count  ()
	);

endmodule

/* rtl/core/jbq_checker.sv */
// Port-level checks of the JPEG block quantizer, bound to its top level.
module jbq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input jbq_pkg::jbq_out_t out_item
);

	// Leaving reset: nothing waiting, input open
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> (empty && !full))
		else $error("queues not idle after reset");

	// A waiting result holds until it is taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("waiting result changed or vanished");

	// Saturation only ever reports a clamped extreme
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_item.saturated) |->
			(out_item.result == 16'sh7FFF || out_item.result == 16'sh8000))
		else $error("saturated flag on an unclamped result");

	// Backpressure only builds up from a transfer just taken
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an input transfer");

endmodule

bind jpeg_block_quantizer_core jbq_checker u_jbq_checker (.*);

/* tb/sv/tb_jpeg_block_quantizer_core.sv */
// Self-checking testbench for the JPEG block quantizer core with a built-in quantization predictor.
`timescale 1ns / 1ps

module tb_jpeg_block_quantizer_core;
	import jbq_pkg::*;

	localparam int DrainCycles = 25;
	localparam int PhaseItems = 240;

	// Unused table select code; the block treats it as the user table
	localparam logic [1:0] TblSpare = 2'd3;

	// Standard tables, kept here so the predictor does not lean on the package copy
	localparam logic [7:0] LumRef [64] = '{
		8'd16, 8'd11, 8'd10, 8'd16, 8'd24, 8'd40, 8'd51, 8'd61,
		8'd12, 8'd12, 8'd14, 8'd19, 8'd26, 8'd58, 8'd60, 8'd55,
		8'd14, 8'd13, 8'd16, 8'd24, 8'd40, 8'd57, 8'd69, 8'd56,
		8'd14, 8'd17, 8'd22, 8'd29, 8'd51, 8'd87, 8'd80, 8'd62,
		8'd18, 8'd22, 8'd37, 8'd56, 8'd68, 8'd109, 8'd103, 8'd77,
		8'd24, 8'd35, 8'd55, 8'd64, 8'd81, 8'd104, 8'd113, 8'd92,
		8'd49, 8'd64, 8'd78, 8'd87, 8'd103, 8'd121, 8'd120, 8'd101,
		8'd72, 8'd92, 8'd95, 8'd98, 8'd112, 8'd100, 8'd103, 8'd99
	};
	localparam logic [7:0] ChrRef [64] = '{
		8'd17, 8'd18, 8'd24, 8'd47, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd18, 8'd21, 8'd26, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd24, 8'd26, 8'd56, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd47, 8'd66, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99,
		8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99, 8'd99
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	jbq_in_t in_item = '0;
	logic empty;
	logic pop = 1'b0;
	jbq_out_t out_item;
	logic cfg_we = 1'b0;
	logic [CfgIndexWidth-1:0] cfg_addr = '0;
	logic [CfgDataWidth-1:0] cfg_wdata = '0;

	// Predictor state
	logic [1:0] sel_model = TblLum;
	logic dir_model = DirFwd;
	logic [7:0] user_model [64];
	logic [63:0] slot_loaded = '0;
	jbq_out_t pending_results [$];
	int fail_count = 0;

	jpeg_block_quantizer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.empty(empty),
		.pop(pop),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Mostly short gaps, some none, a few long ones
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Apply one item to the predictor; return 1 with the expected result for a coefficient
	function automatic bit quantize_item(input jbq_in_t it, output jbq_out_t res);
		logic [7:0] e8;
		int entry, v, q, rem, p;
		res = '0;
		if (it.mode == ModeLoad) begin
			e8 = it.value[7:0];
			user_model[it.position] = (e8 == 8'd0) ? 8'd1 : e8;
			slot_loaded[it.position] = 1'b1;
			return 1'b0;
		end
		case (sel_model)
			TblLum: e8 = LumRef[it.position];
			TblChr: e8 = ChrRef[it.position];
			default: e8 = user_model[it.position];
		endcase
		entry = (e8 == 8'd0) ? 1 : int'(e8);
		v = int'(it.value);
		if (v != 0) begin
			if (dir_model == DirFwd) begin
				q = v / entry;
				rem = v % entry;
				if (v > 0 && 2 * rem >= entry)
					q = q + 1;
				res.result = q[15:0];
			end else begin
				p = v * entry;
				if (p > 32767) begin
					p = 32767;
					res.saturated = 1'b1;
				end else if (p < -32768) begin
					p = -32768;
					res.saturated = 1'b1;
				end
				res.result = p[15:0];
			end
		end
		return 1'b1;
	endfunction

	function automatic jbq_in_t make_item(input logic md, input int pos, input int val);
		jbq_in_t it;
		it.mode = md;
		it.position = pos[5:0];
		it.value = val[15:0];
		return it;
	endfunction

	// Random item; never reads a user slot that was not loaded yet
	function automatic jbq_in_t random_item();
		jbq_in_t it;
		int r;
		it = '0;
		it.position = 6'($urandom_range(0, 63));
		it.mode = ($urandom_range(0, 99) < 15) ? ModeLoad : ModeCoeff;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			it.value = 16'($urandom());
		end else if (r < 60) begin
			it.value = 16'($urandom_range(0, 600) - 300);
		end else if (r < 70) begin
			case ($urandom_range(0, 4))
				0: it.value = 16'h7FFF;
				1: it.value = 16'h8000;
				2: it.value = 16'h0000;
				3: it.value = 16'h0001;
				default: it.value = 16'hFFFF;
			endcase
		end else begin
			it.value = 16'($urandom_range(0, 8000) - 4000);
		end
		if (it.mode == ModeLoad && $urandom_range(0, 9) == 0)
			it.value[7:0] = 8'h00;
		if (it.mode == ModeCoeff && sel_model != TblLum && sel_model != TblChr
				&& !slot_loaded[it.position])
			it.mode = ModeLoad;
		return it;
	endfunction

	// Offer one item and wait for its transfer
	task automatic send_item(input jbq_in_t it);
		int gap;
		jbq_out_t res;
		gap = idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (full);
		if (quantize_item(it, res))
			pending_results.push_back(res);
	endtask

	// Stop pushing and let every outstanding result and load leave the pipe
	task automatic drain_idle();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Write both registers while the block is idle
	task automatic set_config(input logic [1:0] sel, input logic dir);
		drain_idle();
		cfg_we <= 1'b1;
		cfg_addr <= RegTableSel;
		cfg_wdata <= sel;
		@(posedge clk);
		cfg_addr <= RegDirection;
		cfg_wdata <= {1'b0, dir};
		@(posedge clk);
		cfg_we <= 1'b0;
		sel_model = sel;
		dir_model = dir;
	endtask

	task automatic test_rounding_forward();
		// Reset values: luminance table, forward direction
		send_item(make_item(ModeCoeff, 0, 8));
		send_item(make_item(ModeCoeff, 0, 7));
		send_item(make_item(ModeCoeff, 0, -8));
		send_item(make_item(ModeCoeff, 0, 32767));
		send_item(make_item(ModeCoeff, 0, -32768));
		send_item(make_item(ModeCoeff, 63, 0));
		send_item(make_item(ModeCoeff, 63, 50));
		send_item(make_item(ModeCoeff, 63, 49));
		set_config(TblChr, DirFwd);
		send_item(make_item(ModeCoeff, 0, 9));
		send_item(make_item(ModeCoeff, 0, 8));
	endtask

	task automatic test_inverse_saturation();
		set_config(TblLum, DirInv);
		send_item(make_item(ModeCoeff, 61, 270));
		send_item(make_item(ModeCoeff, 61, 271));
		send_item(make_item(ModeCoeff, 61, -271));
		send_item(make_item(ModeCoeff, 61, 32767));
		send_item(make_item(ModeCoeff, 61, -32768));
		send_item(make_item(ModeCoeff, 61, -1));
		send_item(make_item(ModeCoeff, 2, 3276));
	endtask

	task automatic test_user_table_load();
		// Zero entry is stored as one; only the low byte counts
		send_item(make_item(ModeLoad, 5, 0));
		send_item(make_item(ModeLoad, 6, 16'hFF80));
		send_item(make_item(ModeLoad, 7, 16'h7FFF));
		set_config(TblUser, DirInv);
		send_item(make_item(ModeCoeff, 5, 32767));
		send_item(make_item(ModeCoeff, 7, -200));
		set_config(TblSpare, DirInv);
		send_item(make_item(ModeCoeff, 6, -256));
		set_config(TblSpare, DirFwd);
		send_item(make_item(ModeCoeff, 7, 300));
		send_item(make_item(ModeCoeff, 6, -32768));
	endtask

	task automatic test_random_sweep();
		for (int d = 0; d < 2; d++) begin
			for (int s = 0; s < 4; s++) begin
				set_config(s[1:0], d[0]);
				repeat (PhaseItems) send_item(random_item());
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_rounding_forward();
		test_inverse_saturation();
		test_user_table_load();
		test_random_sweep();
		drain_idle();
		if (fail_count == 0)
			$display("jpeg_block_quantizer_core: match");
		else
			$display("jpeg_block_quantizer_core: mismatch");
		$finish;
	end

	// Drive pop with random stalls
	initial begin
		int gap;
		int run;
		wait (arst_n);
		@(posedge clk);
		forever begin
			gap = idle_len();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			run = $urandom_range(1, 20);
			pop <= 1'b1;
			repeat (run) @(posedge clk);
		end
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		jbq_out_t exp_res;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: result %0d saturated %0b",
					$signed(out_item.result), out_item.saturated);
				fail_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (out_item.result !== exp_res.result) begin
					$error("result: expected %0d, actual %0d",
						$signed(exp_res.result), $signed(out_item.result));
					fail_count++;
				end
				if (out_item.saturated !== exp_res.saturated) begin
					$error("saturated: expected %0b, actual %0b",
						exp_res.saturated, out_item.saturated);
					fail_count++;
				end
			end
		end
	end

	// Hard stop if the run hangs
	initial begin
		#15ms;
		$display("jpeg_block_quantizer_core: mismatch");
		$finish;
	end

endmodule

/* files.f */
rtl/core/jbq_pkg.sv
rtl/core/jbq_ram.sv
rtl/core/jbq_fifo.sv
rtl/core/jbq_front.sv
rtl/core/jbq_back.sv
rtl/core/jpeg_block_quantizer_core.sv
rtl/core/jbq_checker.sv
tb/sv/tb_jpeg_block_quantizer_core.sv
